[rtl/core/directed_graph_cycle_check_top_macros.svh]
// assertion macros for the cycle check block
`ifndef DIRECTED_GRAPH_CYCLE_CHECK_TOP_MACROS_SVH
`define DIRECTED_GRAPH_CYCLE_CHECK_TOP_MACROS_SVH

// property that holds on every edge outside reset
`define DGCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked during reset as well
`define DGCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/dgcc_pkg.sv]
`default_nettype none
package dgcc_pkg;
   localparam int unsigned MaxNodesDefault = 256;
   localparam int unsigned MaxEdgesDefault = 1024;
   localparam int unsigned NodeW = 8;
   localparam int unsigned CountW = 9;

   localparam logic [1:0] ErrNone = 2'd0;
   localparam logic [1:0] ErrOverflow = 2'd1;
   localparam logic [1:0] ErrRange = 2'd2;

   localparam logic [1:0] MarkWhite = 2'd0;
   localparam logic [1:0] MarkGrey = 2'd1;
   localparam logic [1:0] MarkBlack = 2'd2;

   typedef struct packed {
      logic [7:0] course;
      logic [7:0] prerequisite;
      logic edge_valid;
      logic last_edge;
   } req_type;

   typedef struct packed {
      logic can_finish;
      logic [1:0] error_code;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_RANGE_RD,
      ST_RANGE_CHK,
      ST_ROOT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store_edge;
      logic clear_start;
      logic clear_step;
      logic range_start;
      logic range_step;
      logic root_next;
      logic root_push;
      logic scan_read;
      logic scan_adv;
      logic push_dst;
      logic pop_top;
      logic set_range_fault;
      logic set_cycle;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic range_done;
      logic range_bad;
      logic fault_set;
      logic roots_done;
      logic root_white;
      logic stack_empty;
      logic scan_end;
      logic scan_match;
      logic dst_out;
      logic dst_grey;
      logic dst_white;
      logic stack_full;
   } sts_type;
endpackage
`default_nettype wire

[rtl/core/dgcc_ram.sv]
`default_nettype none
module dgcc_ram #(
   parameter int unsigned Width = 16,
   parameter int unsigned Depth = 1024
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/core/dgcc_ctrl.sv]
`default_nettype none
module dgcc_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire dgcc_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   input wire dgcc_pkg::sts_type sts,
   output dgcc_pkg::cmd_type cmd
);
   import dgcc_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;

   // loading stalls while a check runs or a result waits
   assign req_stall = (state_ff != ST_LOAD) || rsp_valid_ff;
   assign req_fire = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_data.last_edge) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = sts.fault_set ? ST_DONE : ST_RANGE_RD;
            end
         end
         ST_RANGE_RD: begin
            state_in = sts.range_done ? ST_ROOT : ST_RANGE_CHK;
         end
         ST_RANGE_CHK: begin
            state_in = sts.range_bad ? ST_DONE : ST_RANGE_RD;
         end
         ST_ROOT: begin
            if (sts.roots_done) begin
               state_in = ST_DONE;
            end else if (sts.root_white) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (sts.stack_empty) begin
               state_in = ST_ROOT;
            end else if (!sts.scan_end) begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (sts.scan_match && !sts.dst_out && sts.dst_grey) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.store_edge = req_fire && req_data.edge_valid;
            cmd.clear_start = req_fire && req_data.last_edge;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.range_start = sts.clear_done;
         end
         ST_RANGE_RD: begin
            cmd = '0;
         end
         ST_RANGE_CHK: begin
            // edge under test is on the read port now, move on to the next one if it is in range
            cmd.range_step = !sts.range_bad;
            cmd.set_range_fault = sts.range_bad;
         end
         ST_ROOT: begin
            cmd.root_push = !sts.roots_done && sts.root_white;
            cmd.root_next = !sts.roots_done;
         end
         ST_SCAN_RD: begin
            cmd.scan_read = !sts.stack_empty && !sts.scan_end;
            cmd.pop_top = !sts.stack_empty && sts.scan_end;
         end
         ST_SCAN_CHK: begin
            cmd.scan_adv = 1'b1;
            cmd.set_cycle = sts.scan_match && !sts.dst_out && sts.dst_grey;
            cmd.push_dst = sts.scan_match && !sts.dst_out && sts.dst_white
               && !sts.stack_full;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/dgcc_datapath.sv]
`default_nettype none
module dgcc_datapath #(
   parameter int unsigned MaxNodes = dgcc_pkg::MaxNodesDefault,
   parameter int unsigned MaxEdges = dgcc_pkg::MaxEdgesDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic [dgcc_pkg::CountW-1:0] csr_data,
   input wire dgcc_pkg::req_type req_data,
   input wire dgcc_pkg::cmd_type cmd,
   output dgcc_pkg::sts_type sts,
   output dgcc_pkg::rsp_type rsp_data
);
   import dgcc_pkg::*;

   localparam int unsigned EAW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
   localparam int unsigned ECW = $clog2(MaxEdges + 1);
   localparam int unsigned NAW = $clog2(MaxNodes);
   localparam int unsigned NCW = $clog2(MaxNodes + 1);
   localparam int unsigned FW = NAW + ECW;
   localparam int unsigned EW = 2 * NodeW;

   logic [ECW-1:0] edge_count_ff, edge_count_in;
   logic [1:0] fault_ff, fault_in;
   logic [CountW-1:0] node_count_ff;
   logic cycle_ff, cycle_in;
   logic [NCW-1:0] live_n;
   logic [NCW-1:0] idx_ff, idx_in;
   logic [ECW-1:0] eidx_ff, eidx_in;
   logic [NCW-1:0] sp_ff, sp_in;
   logic [NAW-1:0] top_node_ff, top_node_in;
   logic [ECW-1:0] top_pos_ff, top_pos_in;
   rsp_type rsp_ff, rsp_in;

   logic edge_wr;
   logic [EAW-1:0] edge_wr_addr, edge_rd_addr;
   logic [EW-1:0] edge_wr_data, edge_rd_data;
   logic [NCW-1:0] esrc, edst;

   logic mark_wr;
   logic [NAW-1:0] mark_wr_addr, mark_rd_addr;
   logic [1:0] mark_wr_data, mark_rd_data;

   logic stk_wr;
   logic [NAW-1:0] stk_wr_addr, stk_rd_addr;
   logic [FW-1:0] stk_wr_data, stk_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CountW'(256);
      end else if (csr_write) begin
         node_count_ff <= csr_data;
      end
   end

   assign live_n = (32'(node_count_ff) > MaxNodes) ? NCW'(MaxNodes)
      : NCW'(node_count_ff);

   assign esrc = NCW'(edge_rd_data[NodeW-1:0]);
   assign edst = NCW'(edge_rd_data[EW-1:NodeW]);

   // edge store
   assign edge_wr = cmd.store_edge && (32'(edge_count_ff) < MaxEdges);
   assign edge_wr_addr = EAW'(edge_count_ff);
   assign edge_wr_data = {req_data.course, req_data.prerequisite};
   assign edge_rd_addr = EAW'(eidx_in);

   dgcc_ram #(.Width(EW), .Depth(MaxEdges)) u_edges (
      .clock(clock), .wr_en(edge_wr), .wr_addr(edge_wr_addr),
      .wr_data(edge_wr_data), .rd_addr(edge_rd_addr), .rd_data(edge_rd_data)
   );

   dgcc_ram #(.Width(2), .Depth(MaxNodes)) u_marks (
      .clock(clock), .wr_en(mark_wr), .wr_addr(mark_wr_addr),
      .wr_data(mark_wr_data), .rd_addr(mark_rd_addr), .rd_data(mark_rd_data)
   );

   dgcc_ram #(.Width(FW), .Depth(MaxNodes)) u_stack (
      .clock(clock), .wr_en(stk_wr), .wr_addr(stk_wr_addr),
      .wr_data(stk_wr_data), .rd_addr(stk_rd_addr), .rd_data(stk_rd_data)
   );

   always_comb begin
      edge_count_in = edge_count_ff;
      fault_in = fault_ff;
      cycle_in = cycle_ff;
      idx_in = idx_ff;
      eidx_in = eidx_ff;
      sp_in = sp_ff;
      top_node_in = top_node_ff;
      top_pos_in = top_pos_ff;
      rsp_in = rsp_ff;
      mark_wr = 1'b0;
      mark_wr_addr = NAW'(idx_ff);
      mark_wr_data = MarkWhite;
      mark_rd_addr = NAW'(idx_ff);
      stk_wr = 1'b0;
      stk_wr_addr = NAW'(sp_ff);
      stk_wr_data = {top_node_ff, top_pos_ff};
      stk_rd_addr = NAW'(sp_ff - NCW'(2));

      if (cmd.store_edge) begin
         if (edge_wr) begin
            edge_count_in = edge_count_ff + ECW'(1);
         end else if (fault_ff == ErrNone) begin
            fault_in = ErrOverflow;
         end
      end
      if (cmd.clear_start) begin
         idx_in = '0;
         cycle_in = 1'b0;
      end
      // wipe marks, one per cycle
      if (cmd.clear_step) begin
         mark_wr = 1'b1;
         idx_in = idx_ff + NCW'(1);
      end
      if (cmd.range_start) begin
         eidx_in = '0;
         idx_in = '0;
      end
      if (cmd.range_step) begin
         eidx_in = eidx_ff + ECW'(1);
      end
      if (cmd.set_range_fault) begin
         fault_in = ErrRange;
      end
      if (cmd.root_next) begin
         idx_in = idx_ff + NCW'(1);
         mark_rd_addr = NAW'(idx_ff + NCW'(1));
      end
      if (cmd.root_push) begin
         mark_wr = 1'b1;
         mark_wr_data = MarkGrey;
         top_node_in = NAW'(idx_ff);
         top_pos_in = '0;
         sp_in = NCW'(1);
         eidx_in = '0;
      end
      // hold the edge address so the check sees the same edge
      if (cmd.scan_read) begin
         eidx_in = top_pos_ff;
         top_pos_in = top_pos_ff + ECW'(1);
         mark_rd_addr = NAW'(edst);
      end
      if (cmd.scan_adv) begin
         eidx_in = top_pos_ff;
         mark_rd_addr = NAW'(edst);
      end
      if (cmd.push_dst) begin
         stk_wr = 1'b1;
         stk_wr_addr = NAW'(sp_ff - NCW'(1));
         stk_wr_data = {top_node_ff, top_pos_ff};
         mark_wr = 1'b1;
         mark_wr_addr = NAW'(edst);
         mark_wr_data = MarkGrey;
         top_node_in = NAW'(edst);
         top_pos_in = '0;
         sp_in = sp_ff + NCW'(1);
         eidx_in = '0;
      end
      if (cmd.pop_top) begin
         mark_wr = 1'b1;
         mark_wr_addr = top_node_ff;
         mark_wr_data = MarkBlack;
         sp_in = sp_ff - NCW'(1);
         top_node_in = stk_rd_data[FW-1:ECW];
         top_pos_in = stk_rd_data[ECW-1:0];
         eidx_in = stk_rd_data[ECW-1:0];
         mark_rd_addr = NAW'(idx_ff);
         // prefetch the frame below the new top for a pop in the next cycle
         stk_rd_addr = NAW'(sp_ff - NCW'(3));
      end
      if (cmd.set_cycle) begin
         cycle_in = 1'b1;
      end
      if (cmd.finish) begin
         rsp_in.error_code = fault_ff;
         rsp_in.can_finish = (fault_ff == ErrNone) && !cycle_ff;
         edge_count_in = '0;
         fault_in = ErrNone;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         fault_ff <= ErrNone;
         sp_ff <= '0;
      end else begin
         edge_count_ff <= edge_count_in;
         fault_ff <= fault_in;
         sp_ff <= sp_in;
      end
      cycle_ff <= cycle_in;
      idx_ff <= idx_in;
      eidx_ff <= eidx_in;
      top_node_ff <= top_node_in;
      top_pos_ff <= top_pos_in;
      rsp_ff <= rsp_in;
   end

   assign sts.clear_done = (idx_ff == NCW'(MaxNodes - 1));
   assign sts.fault_set = (fault_ff != ErrNone);
   assign sts.range_done = (eidx_ff >= edge_count_ff);
   assign sts.range_bad = (esrc >= live_n) || (edst >= live_n);
   assign sts.roots_done = (idx_ff >= live_n);
   assign sts.root_white = (mark_rd_data == MarkWhite);
   assign sts.stack_empty = (sp_ff == '0);
   assign sts.scan_end = (top_pos_ff >= edge_count_ff);
   assign sts.scan_match = (esrc == NCW'(top_node_ff));
   assign sts.dst_out = (edst >= live_n);
   assign sts.dst_grey = (mark_rd_data == MarkGrey);
   assign sts.dst_white = (mark_rd_data == MarkWhite);
   assign sts.stack_full = (sp_ff == NCW'(MaxNodes));
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

[rtl/core/directed_graph_cycle_check_top.sv]
// Directed graph cycle check. Edges load at one transfer per cycle while no
// result waits; the transfer marked last starts a check that first clears the
// node marks (one node a cycle), then, unless an edge overflow was flagged,
// scans the edge store once for node indices out of range, stopping at the
// first bad one, then runs a depth-first walk that scans the edge store from
// each frame's saved position.
// Input stalls from the last transfer until the single result is taken.
`default_nettype none
module directed_graph_cycle_check_top #(
   parameter int unsigned MAX_NODES = dgcc_pkg::MaxNodesDefault,
   parameter int unsigned MAX_EDGES = dgcc_pkg::MaxEdgesDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic [dgcc_pkg::CountW-1:0] csr_data,
   input wire logic req_valid,
   output logic req_stall,
   input wire dgcc_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output dgcc_pkg::rsp_type rsp_data
);
   import dgcc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dgcc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   dgcc_datapath #(.MaxNodes(MAX_NODES), .MaxEdges(MAX_EDGES)) u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

[rtl/core/dgcc_checker.sv]
`default_nettype none
`include "directed_graph_cycle_check_top_macros.svh"
module dgcc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire dgcc_pkg::req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire dgcc_pkg::rsp_type rsp_data
);
   import dgcc_pkg::*;

   `DGCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result changed while stalled")
   `DGCC_ASSERT(a_err_legal, clock, reset, rsp_valid |-> rsp_data.error_code <= ErrRange, "bad error code")
   `DGCC_ASSERT(a_err_cycle, clock, reset, rsp_valid && rsp_data.error_code != ErrNone |-> !rsp_data.can_finish, "fault with success")
   `DGCC_ASSERT(a_last_stall, clock, reset, req_valid && !req_stall && req_data.last_edge |=> req_stall, "input taken during check")
   `DGCC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result out of reset")
endmodule
bind directed_graph_cycle_check_top dgcc_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
`default_nettype wire
